[sv/rk_number_converter_assert.svh]
// Assertion macros shared by the RK number converter checkers.
`ifndef RK_NUMBER_CONVERTER_ASSERT_SVH
`define RK_NUMBER_CONVERTER_ASSERT_SVH

// Implication checked at every rising clock edge outside reset.
`define RKC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rk number converter: property failed");

// Condition that must never be seen outside reset.
`define RKC_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("rk number converter: forbidden condition seen");

`endif

[sv/rkc_pkg.sv]
// Types and constants shared by the RK number converter modules.
`default_nettype none

package rkc_pkg;

  // Operation codes
  localparam logic OP_DECODE = 1'b0;
  localparam logic OP_ENCODE = 1'b1;

  // RK word flag bits and mask
  localparam logic [31:0] RK_DIV100_FLAG = 32'h0000_0001;
  localparam logic [31:0] RK_INT_FLAG    = 32'h0000_0002;
  localparam logic [31:0] RK_VALUE_MASK  = 32'hFFFF_FFFC;

  // floor(x/25) = (x * DIV25_MAGIC) >> 35 for any 30-bit x
  localparam logic [30:0] DIV25_MAGIC    = 31'd1374389535;
  // (2^20-1)/25: r/25 in binary is this 20-bit block times r, repeating
  localparam logic [15:0] FRAC25_PERIOD  = 16'd41943;

  localparam logic [10:0] EXP_ALL_ONES   = 11'h7FF;
  localparam logic [63:0] QNAN_BIT       = 64'h0008_0000_0000_0000;

  typedef struct packed {
    logic               op;
    logic signed [31:0] rk_word;
    logic [63:0]        value_bits;
  } in_item_t;

  typedef struct packed {
    logic [63:0]        double_bits;
    logic signed [31:0] rk_result;
    logic               encodable;
  } out_item_t;

  // Outcome of one try of the double and integer forms
  typedef struct packed {
    logic        ok;
    logic [31:0] rk;
  } try_t;

  // Unpacked item after the first stage
  typedef struct packed {
    logic               op;
    logic               sign;
    logic               div;
    logic               bypass;
    logic [63:0]        bypass_bits;
    logic [29:0]        m30;
    logic signed [12:0] e_exp;
    logic [59:0]        prod;
    logic [63:0]        raw;
  } s1_t;

  // Rounder input: value = 1.sig x 2^eu, tail and sticky below
  typedef struct packed {
    logic               sign;
    logic signed [12:0] eu;
    logic [52:0]        sig;
    logic [10:0]        tail;
    logic               sticky;
    logic               bypass;
    logic [63:0]        bypass_bits;
  } rnd_t;

  typedef struct packed {
    logic op;
    rnd_t rnd;
    try_t try1;
  } s3_t;

  typedef struct packed {
    logic        op;
    logic [63:0] dbl;
    try_t        try1;
  } s4_t;

endpackage

`default_nettype wire

[sv/rk_number_converter.sv]
// Top level of the RK number word / IEEE double converter.
// Takes one item per clock whenever start is high; busy stays low, so no item is ever
// refused. The result leaves a five-register pipeline (unpack, divide-by-25 reciprocal
// product, remainder and alignment, rounding, output select) and out_strobe is high
// for one cycle when the item's result leaves the last of these registers.
// The receiver cannot hold a result off; results come out in the order items went in.
`default_nettype none

module rk_number_converter (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire rkc_pkg::in_item_t  in_item,
  output logic                    out_strobe,
  output rkc_pkg::out_item_t      out_item
);

  logic               in_accept;
  logic               s1_vld, s3_vld, s4_vld;
  rkc_pkg::s1_t       s1;
  rkc_pkg::s3_t       s3;
  rkc_pkg::s4_t       s4;
  rkc_pkg::try_t      try2;

  logic               out_strobe_r;
  rkc_pkg::out_item_t out_item_r, out_item_nxt;

  assign busy      = 1'b0;
  assign in_accept = start && !busy;

  rkc_unpack u_unpack (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (in_accept),
    .in_item (in_item),
    .s1_vld  (s1_vld),
    .s1      (s1)
  );

  rkc_scale u_scale (
    .clk    (clk),
    .rst_n  (rst_n),
    .s1_vld (s1_vld),
    .s1     (s1),
    .s3_vld (s3_vld),
    .s3     (s3)
  );

  rkc_round u_round (
    .clk    (clk),
    .rst_n  (rst_n),
    .s3_vld (s3_vld),
    .s3     (s3),
    .s4_vld (s4_vld),
    .s4     (s4)
  );

  // second try on value*100
  rkc_try u_try2 (
    .bits (s4.dbl),
    .res  (try2)
  );

  // output select
  always_comb begin
    out_item_nxt.double_bits = 64'd0;
    out_item_nxt.rk_result   = 32'sd0;
    out_item_nxt.encodable   = 1'b0;
    if (s4.op == rkc_pkg::OP_DECODE) begin
      out_item_nxt.double_bits = s4.dbl;
      out_item_nxt.encodable   = 1'b1;
    end else if (s4.try1.ok) begin
      out_item_nxt.rk_result = $signed(s4.try1.rk);
      out_item_nxt.encodable = 1'b1;
    end else if (try2.ok) begin
      out_item_nxt.rk_result = $signed(try2.rk | rkc_pkg::RK_DIV100_FLAG);
      out_item_nxt.encodable = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_strobe_r <= 1'b0;
    else out_strobe_r <= s4_vld;
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

`default_nettype wire

[sv/rkc_try.sv]
// Tries the RK double form, then the integer form, on one double.
`default_nettype none

module rkc_try (
  input  wire logic [63:0]  bits,
  output rkc_pkg::try_t     res
);

  logic [10:0]        expf;
  logic signed [11:0] eu;
  logic [52:0]        sig;
  logic [5:0]         sh;
  logic [52:0]        ip;
  logic               exact;
  logic [29:0]        mag;
  logic [29:0]        val;
  logic               in_rng;
  logic               rng_ok;

  assign expf   = bits[62:52];
  assign eu     = $signed({1'b0, expf}) - 12'sd1023;
  assign sig    = {1'b1, bits[51:0]};
  assign sh     = 6'd52 - eu[5:0];
  assign ip     = sig >> sh;
  assign exact  = ((ip << sh) == sig);
  assign mag    = ip[29:0];
  assign val    = bits[63] ? (~mag + 30'd1) : mag;
  assign in_rng = (eu >= 12'sd0) && (eu <= 12'sd29);
  // magnitude up to 2^29-1, or exactly 2^29 when negative
  assign rng_ok = !mag[29] || (bits[63] && (mag[28:0] == 29'd0));

  // priority: not finite, double form, integer form
  always_comb begin
    res.ok = 1'b0;
    res.rk = 32'd0;
    if (expf == rkc_pkg::EXP_ALL_ONES) begin
      res.ok = 1'b0;
    end else if ((bits[31:0] == 32'd0) && (bits[33:32] == 2'b00)) begin
      res.ok = 1'b1;
      res.rk = bits[63:32];
    end else if (in_rng && exact && rng_ok) begin
      res.ok = 1'b1;
      res.rk = {val, 2'b00} | rkc_pkg::RK_INT_FLAG;
    end
  end

endmodule

`default_nettype wire

[sv/rkc_unpack.sv]
// Stage 1: unpacks the RK word or the double, normalizes, forms value*100.
`default_nettype none

module rkc_unpack (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_vld,
  input  wire rkc_pkg::in_item_t in_item,
  output logic                   s1_vld,
  output rkc_pkg::s1_t           s1
);

  function automatic logic [4:0] lzc30(input logic [29:0] m);
    logic [4:0] n;
    n = 5'd0;
    for (int i = 0; i < 30; i++) begin
      if (m[i]) n = 5'(29 - i);
    end
    return n;
  endfunction

  logic               s1_vld_r;
  rkc_pkg::s1_t       s1_r, s1_nxt;

  logic [29:0]        s30, mag, m_src;
  logic [31:0]        hi;
  logic [10:0]        exp_h, ex;
  logic [19:0]        f20;
  logic               int_f, div_f;
  logic signed [12:0] e_src;
  logic [4:0]         lz;
  logic               byp_dec;
  logic [63:0]        byp_bits;
  logic [52:0]        mm;
  logic [59:0]        mm_x;

  // decode side: integer or upper-half double, normalized to bit 29
  always_comb begin
    s30   = in_item.rk_word[31:2];
    mag   = in_item.rk_word[31] ? (~s30 + 30'd1) : s30;
    hi    = in_item.rk_word & rkc_pkg::RK_VALUE_MASK;
    exp_h = hi[30:20];
    f20   = hi[19:0];
    int_f = in_item.rk_word[1];
    div_f = in_item.rk_word[0];
    m_src = int_f ? mag : {9'd0, (exp_h != 11'd0), f20};
    if (int_f) e_src = 13'sd0;
    else if (exp_h != 11'd0) e_src = $signed({2'b00, exp_h}) - 13'sd1043;
    else e_src = -13'sd1042;
    lz = lzc30(m_src);
    // zero, plain upper-half double, infinity and NaN skip the arithmetic
    if (int_f) byp_dec = (mag == 30'd0);
    else byp_dec = !div_f || (exp_h == rkc_pkg::EXP_ALL_ONES) ||
                   ((exp_h == 11'd0) && (f20 == 20'd0));
    if (int_f) byp_bits = 64'd0;
    else if (div_f && (exp_h == rkc_pkg::EXP_ALL_ONES) && (f20 != 20'd0))
      byp_bits = {hi, 32'd0} | rkc_pkg::QNAN_BIT;
    else byp_bits = {hi, 32'd0};
  end

  // encode side: exact significand times 100 by shift and add
  always_comb begin
    ex   = in_item.value_bits[62:52];
    mm   = {(ex != 11'd0), in_item.value_bits[51:0]};
    mm_x = {7'd0, mm};
    s1_nxt.op          = in_item.op;
    s1_nxt.div         = div_f;
    s1_nxt.m30         = m_src << lz;
    s1_nxt.prod        = (mm_x << 6) + (mm_x << 5) + (mm_x << 2);
    s1_nxt.raw         = in_item.value_bits;
    s1_nxt.bypass_bits = byp_bits;
    if (in_item.op == rkc_pkg::OP_ENCODE) begin
      s1_nxt.sign   = in_item.value_bits[63];
      s1_nxt.bypass = 1'b0;
      s1_nxt.e_exp  = $signed({2'b00, (ex == 11'd0) ? 11'd1 : ex}) - 13'sd1075;
    end else begin
      s1_nxt.sign   = int_f ? in_item.rk_word[31] : hi[31];
      s1_nxt.bypass = byp_dec;
      s1_nxt.e_exp  = e_src - $signed({8'd0, lz});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else s1_vld_r <= in_vld;
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
  end

  assign s1_vld = s1_vld_r;
  assign s1     = s1_r;

endmodule

`default_nettype wire

[sv/rkc_scale.sv]
// Stages 2-3: divide by 25 with exact remainder, or align value*100.
`default_nettype none

module rkc_scale (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         s1_vld,
  input  wire rkc_pkg::s1_t s1,
  output logic              s3_vld,
  output rkc_pkg::s3_t      s3
);

  typedef struct packed {
    logic               op;
    logic               sign;
    logic               div;
    logic               bypass;
    logic [63:0]        bypass_bits;
    logic [29:0]        m30;
    logic signed [12:0] e_exp;
    logic [25:0]        q;
    rkc_pkg::rnd_t      enc;
    rkc_pkg::try_t      try1;
  } s2_t;

  logic          s2_vld_r, s3_vld_r;
  s2_t           s2_r, s2_nxt;
  rkc_pkg::s3_t  s3_r, s3_nxt;

  logic [60:0]   qf;
  logic [7:0]    hi8;
  logic [2:0]    idx;
  logic [59:0]   norm;
  logic          nan_in;
  rkc_pkg::try_t try1;

  logic [29:0]   q25;
  logic [29:0]   diff;
  logic [4:0]    r;
  logic [20:0]   fm;
  logic [19:0]   frac;
  logic [85:0]   x;
  rkc_pkg::rnd_t rnd_dec;

  // first try on the unscaled value
  rkc_try u_try1 (
    .bits (s1.raw),
    .res  (try1)
  );

  // stage 2: quotient by reciprocal; product leading-one pick
  always_comb begin
    qf     = 61'(s1.m30) * 61'(rkc_pkg::DIV25_MAGIC);
    hi8    = s1.prod[59:52];
    idx    = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (hi8[i]) idx = 3'(i);
    end
    norm   = s1.prod << (3'd7 - idx);
    nan_in = (s1.raw[62:52] == rkc_pkg::EXP_ALL_ONES);

    s2_nxt.op          = s1.op;
    s2_nxt.sign        = s1.sign;
    s2_nxt.div         = s1.div;
    s2_nxt.bypass      = s1.bypass;
    s2_nxt.bypass_bits = s1.bypass_bits;
    s2_nxt.m30         = s1.m30;
    s2_nxt.e_exp       = s1.e_exp;
    s2_nxt.q           = qf[60:35];
    s2_nxt.try1        = try1;

    s2_nxt.enc.sign    = s1.sign;
    s2_nxt.enc.eu      = s1.e_exp + 13'sd52 + $signed({10'd0, idx});
    s2_nxt.enc.sig     = norm[59:7];
    s2_nxt.enc.tail    = {norm[6:0], 4'd0};
    s2_nxt.enc.sticky  = 1'b0;
    // product still subnormal is exact; NaN/inf input forced to fail later
    s2_nxt.enc.bypass  = nan_in || (hi8 == 8'd0);
    if (nan_in) s2_nxt.enc.bypass_bits = {s1.sign, rkc_pkg::EXP_ALL_ONES, 52'd0};
    else s2_nxt.enc.bypass_bits = {s1.sign, 11'd0, s1.prod[51:0]};
  end

  // stage 3: remainder, repeating fraction of r/25, rounder input
  always_comb begin
    q25  = {s2_r.q, 4'd0} + {1'b0, s2_r.q, 3'd0} + {4'd0, s2_r.q};
    diff = s2_r.m30 - q25;
    r    = diff[4:0];
    fm   = 21'(r) * 21'(rkc_pkg::FRAC25_PERIOD);
    frac = fm[19:0];
    x    = {s2_r.q, frac, frac, frac};

    rnd_dec.sign        = s2_r.sign;
    rnd_dec.bypass      = s2_r.bypass;
    rnd_dec.bypass_bits = s2_r.bypass_bits;
    if (!s2_r.div) begin
      rnd_dec.sig    = {s2_r.m30, 23'd0};
      rnd_dec.tail   = 11'd0;
      rnd_dec.sticky = 1'b0;
      rnd_dec.eu     = s2_r.e_exp + 13'sd29;
    end else if (s2_r.q[25]) begin
      rnd_dec.sig    = x[85:33];
      rnd_dec.tail   = x[32:22];
      rnd_dec.sticky = (r != 5'd0);
      rnd_dec.eu     = s2_r.e_exp + 13'sd23;
    end else begin
      rnd_dec.sig    = x[84:32];
      rnd_dec.tail   = x[31:21];
      rnd_dec.sticky = (r != 5'd0);
      rnd_dec.eu     = s2_r.e_exp + 13'sd22;
    end

    s3_nxt.op   = s2_r.op;
    s3_nxt.rnd  = (s2_r.op == rkc_pkg::OP_ENCODE) ? s2_r.enc : rnd_dec;
    s3_nxt.try1 = s2_r.try1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_r <= s2_nxt;
    s3_r <= s3_nxt;
  end

  assign s3_vld = s3_vld_r;
  assign s3     = s3_r;

endmodule

`default_nettype wire

[sv/rkc_round.sv]
// Stage 4: round to nearest even into a double, subnormal and overflow aware.
`default_nettype none

module rkc_round (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         s3_vld,
  input  wire rkc_pkg::s3_t s3,
  output logic              s4_vld,
  output rkc_pkg::s4_t      s4
);

  logic               s4_vld_r;
  rkc_pkg::s4_t       s4_r, s4_nxt;

  logic               under, ovf, lost, g, st, inc;
  logic signed [12:0] nd, ebias;
  logic [5:0]         d;
  logic [63:0]        ext, shifted;
  logic [52:0]        mant;
  logic [10:0]        efield;
  logic [62:0]        sum;

  always_comb begin
    under  = s3.rnd.eu < -13'sd1022;
    nd     = -13'sd1022 - s3.rnd.eu;
    if (!under) d = 6'd0;
    else if (nd > 13'sd63) d = 6'd63;
    else d = nd[5:0];
    // denormalize, anything shifted out joins the sticky bit
    ext     = {s3.rnd.sig, s3.rnd.tail};
    shifted = ext >> d;
    lost    = ((shifted << d) != ext);
    mant    = shifted[63:11];
    g       = shifted[10];
    st      = (|shifted[9:0]) || lost || s3.rnd.sticky;
    inc     = g && (st || mant[0]);
    ebias   = s3.rnd.eu + 13'sd1023;
    efield  = under ? 11'd0 : ebias[10:0];
    ovf     = !under && (s3.rnd.eu > 13'sd1023);
    // carry out of the fraction bumps the exponent field
    sum     = {efield, mant[51:0]} + {62'd0, inc};

    s4_nxt.op   = s3.op;
    s4_nxt.try1 = s3.try1;
    if (s3.rnd.bypass) s4_nxt.dbl = s3.rnd.bypass_bits;
    else if (ovf) s4_nxt.dbl = {s3.rnd.sign, rkc_pkg::EXP_ALL_ONES, 52'd0};
    else s4_nxt.dbl = {s3.rnd.sign, sum};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s4_vld_r <= 1'b0;
    else s4_vld_r <= s3_vld;
  end

  always_ff @(posedge clk) begin
    s4_r <= s4_nxt;
  end

  assign s4_vld = s4_vld_r;
  assign s4     = s4_r;

endmodule

`default_nettype wire

[sv/rkc_checker.sv]
// Port-level checks for the RK number converter, bound to the top level.
`default_nettype none

`include "rk_number_converter_assert.svh"

module rkc_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire rkc_pkg::in_item_t  in_item,
  input wire logic               out_strobe,
  input wire rkc_pkg::out_item_t out_item
);

  // every result traces back to an item that the top level took
  `RKC_ASSERT_IMP(a_strobe_latency, clk, rst_n, out_strobe, $past(start && !busy, 5))
  // decode results are always encodable and carry no RK word
  `RKC_ASSERT_IMP(a_decode_fields, clk, rst_n, out_strobe && ($past(in_item.op, 5) == rkc_pkg::OP_DECODE), out_item.encodable && (out_item.rk_result == 32'sd0))
  // encode results carry no double
  `RKC_ASSERT_IMP(a_encode_fields, clk, rst_n, out_strobe && ($past(in_item.op, 5) == rkc_pkg::OP_ENCODE), out_item.double_bits == 64'd0)
  // a failed encode reports a zero word
  `RKC_ASSERT_NEVER(a_fail_word_zero, clk, rst_n, out_strobe && !out_item.encodable && (out_item.rk_result != 32'sd0))

endmodule

bind rk_number_converter rkc_checker u_rkc_checker (.*);

`default_nettype wire
